// File: rtl/assert_macros.svh
// Assertion macros used by the RTL files (rau_back includes them).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: rtl/rau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;
    localparam int IN_WIDTH_DEF = 16;
    localparam int NUM_W = 33;
    localparam int DEN_W = 31;
    localparam int MAG_W = 64;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    // Classified item handed from front to back.
    typedef struct packed {
        logic             zero_den;
        logic             neg;
        logic [MAG_W-1:0] nm;
        logic [MAG_W-1:0] dm;
    } t_job;
endpackage
`default_nettype wire

// File: rtl/rau_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rau_front
    import rau_pkg::*;
#(
    parameter int IN_WIDTH = IN_WIDTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [1:0]                 i_kind,
    input  wire logic signed [IN_WIDTH-1:0] i_a_num,
    input  wire logic signed [IN_WIDTH-1:0] i_a_den,
    input  wire logic signed [IN_WIDTH-1:0] i_b_num,
    input  wire logic signed [IN_WIDTH-1:0] i_b_den,
    output logic                            o_job_valid,
    input  wire logic                       i_job_stall,
    output t_job                            o_job
);
    localparam int PW = 2 * IN_WIDTH;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_SUM, S_OUT} t_state;

    t_state r_state, n_state;
    t_op r_op, n_op;
    logic signed [IN_WIDTH-1:0] r_an, r_ad, r_bn, r_bd, n_an, n_ad, n_bn, n_bd;
    logic signed [PW-1:0] r_p0, r_p1, r_pd, n_p0, n_p1, n_pd;
    t_job r_job, n_job;
    logic [MAG_W-1:0] w_n, w_d, w_p0, w_p1;

    assign w_p0 = MAG_W'($signed(r_p0));
    assign w_p1 = MAG_W'($signed(r_p1));

    always_comb begin
        n_state = r_state;
        n_op = r_op;
        n_an = r_an; n_ad = r_ad; n_bn = r_bn; n_bd = r_bd;
        n_p0 = r_p0; n_p1 = r_p1; n_pd = r_pd;
        n_job = r_job;
        w_n = '0;
        w_d = MAG_W'($signed(r_pd));
        unique case (r_op)
            OP_ADD: w_n = w_p0 + w_p1;
            OP_SUB: w_n = w_p0 - w_p1;
            default: w_n = w_p0;
        endcase
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op = t_op'(i_kind);
                    n_an = i_a_num; n_ad = i_a_den; n_bn = i_b_num; n_bd = i_b_den;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                unique case (r_op)
                    OP_MUL: begin
                        n_p0 = r_an * r_bn;
                        n_pd = r_ad * r_bd;
                    end
                    OP_DIV: begin
                        n_p0 = r_an * r_bd;
                        n_pd = r_ad * r_bn;
                    end
                    default: begin
                        n_p0 = r_an * r_bd;
                        n_pd = r_ad * r_bd;
                    end
                endcase
                n_state = S_SUM;
            end
            S_SUM: begin
                // Second cross product for the sum and difference cases.
                n_p1 = r_ad * r_bn;
                n_state = S_OUT;
            end
            S_OUT: begin
                n_job.zero_den = (w_d == '0);
                n_job.neg = w_n[MAG_W-1] ^ w_d[MAG_W-1];
                n_job.nm = w_n[MAG_W-1] ? (MAG_W'(0) - w_n) : w_n;
                n_job.dm = w_d[MAG_W-1] ? (MAG_W'(0) - w_d) : w_d;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    logic r_jv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_jv <= 1'b0;
        end else begin
            if (r_state == S_OUT && !(r_jv && i_job_stall)) begin
                r_state <= n_state;
                r_jv <= 1'b1;
            end else begin
                if (r_jv && !i_job_stall) r_jv <= 1'b0;
                if (r_state != S_OUT) r_state <= n_state;
            end
        end
        if (!(r_state == S_OUT && r_jv && i_job_stall)) begin
            r_op <= n_op;
            r_an <= n_an; r_ad <= n_ad; r_bn <= n_bn; r_bd <= n_bd;
            r_p0 <= n_p0; r_p1 <= n_p1; r_pd <= n_pd;
            if (r_state == S_OUT) r_job <= n_job;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_job_valid = r_jv;
    assign o_job = r_job;
endmodule
`default_nettype wire

// File: rtl/rau_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module rau_queue
    import rau_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_job i_job,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_job      o_job
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    t_job r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0] r_cnt;
    logic w_push, w_pop;

    assign o_stall = (r_cnt == (AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign w_push = i_valid && !o_stall;
    assign w_pop = o_valid && !i_stall;
    assign o_job = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
        if (w_push) r_mem[r_wp] <= i_job;
    end
endmodule
`default_nettype wire

// File: rtl/rau_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rau_back
    import rau_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire t_job                    i_job,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic signed [NUM_W-1:0]      o_res_num,
    output logic [DEN_W-1:0]             o_res_den,
    output logic                         o_is_whole,
    output logic                         o_zero_den
);
    localparam int CW = $clog2(MAG_W + 1);
    typedef enum logic [2:0] {S_IDLE, S_MOD, S_GCD, S_DIVN, S_DIVD, S_DONE} t_state;

    t_state r_state;
    t_job r_job;
    logic [MAG_W-1:0] r_x, r_y;      // Euclid pair
    logic [MAG_W-1:0] r_rem, r_quo, r_dvd, r_dvs;
    logic [CW-1:0] r_cnt;
    logic [MAG_W-1:0] r_rn;
    logic r_ov;
    logic signed [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic r_whole, r_zd;
    logic [MAG_W:0] w_sh;
    logic [MAG_W:0] w_diff;

    // One restoring division bit per cycle.
    assign w_sh = {r_rem, r_dvd[MAG_W-1]};
    assign w_diff = w_sh - {1'b0, r_dvs};

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            if (r_ov && !i_stall) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_job <= i_job;
                        r_x <= i_job.nm;
                        r_y <= i_job.dm;
                        r_state <= i_job.zero_den ? S_DONE : S_GCD;
                    end
                end
                S_GCD: begin
                    if (r_x == '0) begin
                        // r_y holds the gcd; divide numerator first.
                        r_dvs <= r_y;
                        r_dvd <= r_job.nm;
                        r_rem <= '0;
                        r_cnt <= '0;
                        r_state <= S_DIVN;
                    end else begin
                        r_dvs <= r_x;
                        r_dvd <= r_y;
                        r_rem <= '0;
                        r_cnt <= '0;
                        r_state <= S_MOD;
                    end
                end
                S_MOD, S_DIVN, S_DIVD: begin
                    r_dvd <= {r_dvd[MAG_W-2:0], ~w_diff[MAG_W]};
                    r_rem <= w_diff[MAG_W] ? w_sh[MAG_W-1:0] : w_diff[MAG_W-1:0];
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(MAG_W - 1)) begin
                        r_cnt <= '0;
                        unique case (r_state)
                            S_MOD: begin
                                r_y <= r_x;
                                r_x <= w_diff[MAG_W] ? w_sh[MAG_W-1:0] : w_diff[MAG_W-1:0];
                                r_state <= S_GCD;
                            end
                            S_DIVN: begin
                                r_rn <= {r_dvd[MAG_W-2:0], ~w_diff[MAG_W]};
                                r_dvd <= r_job.dm;
                                r_rem <= '0;
                                r_state <= S_DIVD;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_DONE: begin
                    if (!r_ov || !i_stall) begin
                        r_ov <= 1'b1;
                        r_zd <= r_job.zero_den;
                        if (r_job.zero_den) begin
                            r_num <= '0; r_den <= '0; r_whole <= 1'b0;
                        end else begin
                            r_num <= (r_job.neg && r_rn != '0) ? NUM_W'(MAG_W'(0) - r_rn)
                                                               : NUM_W'(r_rn);
                            r_den <= DEN_W'(r_dvd);
                            r_whole <= (r_dvd == MAG_W'(1));
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_res_num = r_num;
    assign o_res_den = r_den;
    assign o_is_whole = r_whole;
    assign o_zero_den = r_zd;

    `ASSERT_CLK(a_zd_out, i_clk, i_rst_n, (r_ov && r_zd) |-> (r_den == '0 && !r_whole), "zero denominator result not 0/0")
    `ASSERT_CLK(a_whole, i_clk, i_rst_n, (r_ov && !r_zd) |-> (r_whole == (r_den == DEN_W'(1))), "whole flag mismatch")
    `ASSERT_CLK(a_den_pos, i_clk, i_rst_n, (r_ov && !r_zd) |-> (r_den != '0), "zero denominator without flag")
    `ASSERT_CLK(a_hold, i_clk, i_rst_n, (r_ov && i_stall) |=> (r_ov && $stable(r_num)), "stalled result changed")
endmodule
`default_nettype wire

// File: rtl/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// The front end forms the cross products and signs in turn, a two-entry queue holds
// finished jobs, and the back end runs Euclid on a 64-bit bit-serial divider, then
// divides the numerator and the denominator by the gcd. Each stage takes a new item only
// once it is done with the last, but the queue lets the front end work ahead of the back end.
// Reset: synchronous, active low; clears the state machines, the valid flags and the queue.
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int IN_WIDTH = IN_WIDTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [1:0]                 i_kind,
    input  wire logic signed [IN_WIDTH-1:0] i_a_num,
    input  wire logic signed [IN_WIDTH-1:0] i_a_den,
    input  wire logic signed [IN_WIDTH-1:0] i_b_num,
    input  wire logic signed [IN_WIDTH-1:0] i_b_den,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic signed [NUM_W-1:0]         o_res_num,
    output logic [DEN_W-1:0]                o_res_den,
    output logic                            o_is_whole,
    output logic                            o_zero_den
);
    // The front end forms the cross products and signs; a short queue
    // decouples it from the back end, which runs Euclid and the reductions.
    logic w_fv, w_fs, w_qv, w_qs;
    t_job w_fj, w_qj;

    rau_front #(.IN_WIDTH(IN_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_kind, .i_a_num, .i_a_den, .i_b_num, .i_b_den,
        .o_job_valid(w_fv), .i_job_stall(w_fs), .o_job(w_fj)
    );

    rau_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(w_fv), .o_stall(w_fs), .i_job(w_fj),
        .o_valid(w_qv), .i_stall(w_qs), .o_job(w_qj)
    );

    rau_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_qv), .o_stall(w_qs), .i_job(w_qj),
        .o_valid, .i_stall, .o_res_num, .o_res_den, .o_is_whole, .o_zero_den
    );
endmodule
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import rau_pkg::*;

    localparam int W         = 16;
    localparam int HOLD_LEN  = 3000;
    localparam int WDOG_MAX  = 40000;
    localparam int DRAIN_CYC = 4000;

    typedef struct {
        t_op                    kind;
        logic signed [W-1:0]    an;
        logic signed [W-1:0]    ad;
        logic signed [W-1:0]    bn;
        logic signed [W-1:0]    bd;
    } t_operands;

    typedef struct {
        logic signed [NUM_W-1:0] num;
        logic [DEN_W-1:0]        den;
        logic                    whole;
        logic                    zd;
    } t_fraction;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic [1:0]              i_kind;
    logic signed [W-1:0]     i_a_num;
    logic signed [W-1:0]     i_a_den;
    logic signed [W-1:0]     i_b_num;
    logic signed [W-1:0]     i_b_den;
    logic                    o_valid;
    logic                    i_stall;
    logic signed [NUM_W-1:0] o_res_num;
    logic [DEN_W-1:0]        o_res_den;
    logic                    o_is_whole;
    logic                    o_zero_den;

    t_operands pending_ops[$];
    t_fraction awaited_fracs[$];
    int        mismatches = 0;
    int        idle_cycles = 0;
    logic      quiet = 1'b0;       // no random idling on either side while set
    logic      hold_start = 1'b0;  // asks the monitor for one long hold-off
    logic      hold_taken = 1'b0;
    int        hold_left = 0;

    rational_arithmetic_unit #(.IN_WIDTH(W)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_kind(i_kind), .i_a_num(i_a_num), .i_a_den(i_a_den),
        .i_b_num(i_b_num), .i_b_den(i_b_den),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_res_num(o_res_num), .o_res_den(o_res_den),
        .o_is_whole(o_is_whole), .o_zero_den(o_zero_den)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Cross products, then both magnitudes divided by their gcd (a zero denominator
    // gives a flagged 0/0); the sign ends up on the numerator, the denominator positive.
    function automatic t_fraction reduce_fraction(t_operands op);
        longint    an, ad, bn, bd;
        logic [63:0] n, d, x, y, r, nm, dm, rn, rd;
        logic      neg;
        t_fraction f;
        an = op.an;
        ad = op.ad;
        bn = op.bn;
        bd = op.bd;
        case (op.kind)
            OP_ADD: begin
                n = an * bd + ad * bn;
                d = ad * bd;
            end
            OP_SUB: begin
                n = an * bd - ad * bn;
                d = ad * bd;
            end
            OP_MUL: begin
                n = an * bn;
                d = ad * bd;
            end
            default: begin
                n = an * bd;
                d = ad * bn;
            end
        endcase
        if (d == 64'd0) begin
            f.num = '0;
            f.den = '0;
            f.whole = 1'b0;
            f.zd = 1'b1;
            return f;
        end
        neg = n[63] ^ d[63];
        nm = n[63] ? -n : n;
        dm = d[63] ? -d : d;
        x = nm;
        y = dm;
        while (x != 64'd0) begin
            r = y % x;
            y = x;
            x = r;
        end
        rn = nm / y;
        rd = dm / y;
        if (rn == 64'd0)
            neg = 1'b0;
        if (neg)
            rn = -rn;
        f.num = rn[NUM_W-1:0];
        f.den = rd[DEN_W-1:0];
        f.whole = (rd == 64'd1);
        f.zd = 1'b0;
        return f;
    endfunction

    function automatic logic signed [W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: return 16'sh8000;
                    1: return 16'sd32767;
                    2: return 16'sd0;
                    3: return 16'sd1;
                    default: return -16'sd1;
                endcase
            end
            1, 2, 3, 4: return W'($signed($urandom_range(0, 40)) - 20);
            default: return W'($urandom);
        endcase
    endfunction

    task automatic queue_op(t_op k, int an, int ad, int bn, int bd);
        t_operands op;
        op.kind = k;
        op.an = W'(an);
        op.ad = W'(ad);
        op.bn = W'(bn);
        op.bd = W'(bd);
        pending_ops.push_back(op);
    endtask

    task automatic queue_random(int count);
        t_operands op;
        repeat (count) begin
            op.kind = t_op'($urandom_range(0, 3));
            op.an = pick_value();
            op.ad = pick_value();
            op.bn = pick_value();
            op.bd = pick_value();
            pending_ops.push_back(op);
        end
    endtask

    // Driver: a new beat is offered only once the current one has been taken,
    // so a stalled payload never changes.
    always @(posedge i_clk) begin
        t_operands op;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                op.kind = t_op'(i_kind);
                op.an = i_a_num;
                op.ad = i_a_den;
                op.bn = i_b_num;
                op.bd = i_b_den;
                awaited_fracs.push_back(reduce_fraction(op));
            end
            if (!i_valid || !o_stall) begin
                if (pending_ops.size() != 0 && (quiet || $urandom_range(0, 99) >= 9)) begin
                    op = pending_ops.pop_front();
                    i_valid <= 1'b1;
                    i_kind <= op.kind;
                    i_a_num <= op.an;
                    i_a_den <= op.ad;
                    i_b_num <= op.bn;
                    i_b_den <= op.bd;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each output beat, drives the output stall and watches
    // for a unit that has stopped making progress.
    always @(posedge i_clk) begin
        t_fraction exp_f;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (awaited_fracs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result beat: %0d/%0d", o_res_num, o_res_den);
                end else begin
                    exp_f = awaited_fracs.pop_front();
                    if (o_res_num !== exp_f.num || o_res_den !== exp_f.den ||
                        o_is_whole !== exp_f.whole || o_zero_den !== exp_f.zd) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Mismatch: expected %0d/%0d whole %b zero %b, ",
                                      "got %0d/%0d whole %b zero %b"},
                                     exp_f.num, exp_f.den, exp_f.whole, exp_f.zd,
                                     o_res_num, o_res_den, o_is_whole, o_zero_den);
                    end
                end
            end

            if ((o_valid && !i_stall) || (i_valid && !o_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("*** FAILED ***");
                $finish;
            end else begin
                // One long hold-off lets the unit fill up and push back on its input.
                if (hold_start && !hold_taken) begin
                    hold_taken <= 1'b1;
                    hold_left <= HOLD_LEN;
                    i_stall <= 1'b1;
                end else if (hold_left > 0) begin
                    hold_left <= hold_left - 1;
                    i_stall <= (hold_left > 1);
                end else begin
                    i_stall <= !quiet && ($urandom_range(0, 99) < 9);
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_kind = OP_ADD;
        i_a_num = '0;
        i_a_den = '0;
        i_b_num = '0;
        i_b_den = '0;

        // Directed beats: every operation, extreme operands, zero denominators,
        // zero numerators and whole-number results.
        queue_op(OP_ADD, 1, 2, 1, 3);
        queue_op(OP_SUB, 1, 2, 1, 2);
        queue_op(OP_MUL, 2, 3, 3, 4);
        queue_op(OP_DIV, 1, 2, 1, 4);
        queue_op(OP_ADD, 3, 0, 1, 5);
        queue_op(OP_MUL, 7, 3, 2, 0);
        queue_op(OP_DIV, 5, 7, 0, 3);
        queue_op(OP_MUL, 0, 5, 9, 4);
        queue_op(OP_SUB, 0, -7, 0, 3);
        queue_op(OP_ADD, -32768, -32768, -32768, -32768);
        queue_op(OP_SUB, -32768, 1, 32767, 1);
        queue_op(OP_MUL, -32768, 1, -32768, 1);
        queue_op(OP_MUL, 1, -32768, 1, -32768);
        queue_op(OP_DIV, 32767, -32768, -32768, 32767);
        queue_op(OP_ADD, 32767, 32766, 32767, 32765);
        queue_op(OP_SUB, -1, -1, 1, -1);
        queue_op(OP_DIV, -6, 4, 3, -2);
        queue_op(OP_MUL, -32768, 32767, 32767, -32768);
        queue_op(OP_ADD, 28657, 17711, -17711, 10946);
        queue_op(OP_DIV, -1, 32767, -1, -32768);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The sender pauses here until every awaited result has come back.
        wait (pending_ops.size() == 0 && !i_valid && awaited_fracs.size() == 0);

        hold_start = 1'b1;
        queue_random(200);
        wait (pending_ops.size() < 20);
        quiet = 1'b1;
        queue_random(150);
        wait (pending_ops.size() == 0);
        quiet = 1'b0;
        queue_random(280);

        wait (pending_ops.size() == 0 && !i_valid && awaited_fracs.size() == 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatches == 0 && awaited_fracs.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire

// File: rational_arithmetic_unit.f
+incdir+rtl
rtl/rau_pkg.sv
rtl/rau_front.sv
rtl/rau_queue.sv
rtl/rau_back.sv
rtl/rational_arithmetic_unit.sv
verif/testbench.sv
